// ----- design/tli_pkg.sv -----
// Shared types and constants of the terminal line input unit.
// Used by tli_decode and terminal_line_input_unit; no dependencies.
package tli_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int AddrW      = $clog2(LINE_DEPTH);
  localparam int CountW     = 6;
  localparam int ByteW      = 8;

  localparam logic [ByteW-1:0] BYTE_BELL     = 8'd7;
  localparam logic [ByteW-1:0] BYTE_BS       = 8'd8;
  localparam logic [ByteW-1:0] BYTE_LF       = 8'd10;
  localparam logic [ByteW-1:0] BYTE_CR       = 8'd13;
  localparam logic [ByteW-1:0] BYTE_ESC      = 8'd27;
  localparam logic [ByteW-1:0] BYTE_SPACE    = 8'h20;
  localparam logic [ByteW-1:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [ByteW-1:0] BYTE_TILDE    = 8'h7E;
  localparam logic [ByteW-1:0] BYTE_DEL      = 8'd127;
  localparam logic [ByteW-1:0] BYTE_ZERO     = 8'd0;

  localparam logic [CountW-1:0] LIMIT_RESET = 6'd63;
  localparam logic [CountW-1:0] CHAR_CAP    = CountW'(LINE_DEPTH - 2);

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_AFTER = 2'd1,
    ESC_CSI   = 2'd2
  } esc_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ECHO  = 2'd1,
    ACT_ERASE = 2'd2,
    ACT_ENTER = 2'd3
  } act_e;

  typedef struct packed {
    act_e              act;
    logic [ByteW-1:0]  echo_byte;
    esc_e              esc_next;
    logic              store;
    logic [CountW-1:0] count_next;
  } decode_t;

endpackage

// ----- design/tli_decode.sv -----
// Byte classifier: escape tracking, line room check and next character count.
// Depends on tli_pkg.
module tli_decode (
  input  logic [tli_pkg::ByteW-1:0]  rx_byte_i,
  input  logic                       more_waiting_i,
  input  tli_pkg::esc_e              esc_i,
  input  logic [tli_pkg::CountW-1:0] count_i,
  input  logic [tli_pkg::CountW-1:0] limit_i,
  output tli_pkg::decode_t           dec_o
);

  logic [tli_pkg::CountW-1:0] cap;
  logic                       printable;

  always_comb begin
    if (limit_i <= 6'd1) begin
      cap = '0;
    end else if (limit_i - 6'd1 > tli_pkg::CHAR_CAP) begin
      cap = tli_pkg::CHAR_CAP;
    end else begin
      cap = limit_i - 6'd1;
    end
  end

  assign printable = (rx_byte_i >= tli_pkg::BYTE_SPACE) && (rx_byte_i <= tli_pkg::BYTE_TILDE);

  always_comb begin
    dec_o            = '0;
    dec_o.act        = tli_pkg::ACT_NONE;
    dec_o.echo_byte  = rx_byte_i;
    dec_o.esc_next   = tli_pkg::ESC_IDLE;
    dec_o.store      = 1'b0;
    dec_o.count_next = count_i;
    unique case (esc_i)
      tli_pkg::ESC_AFTER: begin
        if (rx_byte_i == tli_pkg::BYTE_LBRACKET) begin
          dec_o.esc_next = tli_pkg::ESC_CSI;
        end
      end
      tli_pkg::ESC_CSI: begin
        dec_o.esc_next = tli_pkg::ESC_IDLE;
      end
      default: begin
        if (rx_byte_i == tli_pkg::BYTE_CR || rx_byte_i == tli_pkg::BYTE_LF) begin
          dec_o.act        = tli_pkg::ACT_ENTER;
          dec_o.count_next = '0;
        end else if (rx_byte_i == tli_pkg::BYTE_BS || rx_byte_i == tli_pkg::BYTE_DEL) begin
          if (count_i != '0) begin
            dec_o.act        = tli_pkg::ACT_ERASE;
            dec_o.count_next = count_i - 6'd1;
          end
        end else if (rx_byte_i == tli_pkg::BYTE_ESC) begin
          if (more_waiting_i) begin
            dec_o.esc_next = tli_pkg::ESC_AFTER;
          end
        end else if (printable) begin
          dec_o.act = tli_pkg::ACT_ECHO;
          if (count_i >= cap) begin
            dec_o.echo_byte = tli_pkg::BYTE_BELL;
          end else begin
            dec_o.store      = 1'b1;
            dec_o.count_next = count_i + 6'd1;
          end
        end
      end
    endcase
  end

endmodule

// ----- design/terminal_line_input_unit.sv -----
// Top level of the terminal line input unit: sequencer, line store and output register.
// Depends on tli_pkg and tli_decode.
//
//   channel | direction | handshake              | payload
//   input   | in        | in_valid_i / in_stall_o | rx_byte_i, more_waiting_i
//   output  | out       | out_valid_o / out_stall_i | kind_o, value_o, last_o
//   config  | in        | cfg_we_i               | cfg_wdata_i (line_limit)
//
// Items are taken one at a time; each echo result then goes to the output register.
// Enter sends stored characters: S_LREAD registers a line store read, S_LDATA sends it.
// An item with no result frees the input at once; otherwise the input stalls
// until its last result sits in the output register. Output stall holds the sequencer.
// Reset clears count and escape state, sets limit to 63; the line store is not cleared.
module terminal_line_input_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tli_pkg::ByteW-1:0]  rx_byte_i,
  input  logic                       more_waiting_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [tli_pkg::ByteW-1:0]  value_o,
  output logic                       last_o,
  input  logic                       cfg_we_i,
  input  logic [tli_pkg::CountW-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_LREAD,
    S_LDATA
  } state_e;

  state_e                     state_q;
  tli_pkg::act_e              act_q;
  logic [1:0]                 step_q;
  logic [tli_pkg::ByteW-1:0]  echo_q;
  logic [tli_pkg::CountW-1:0] line_len_q;
  logic [tli_pkg::AddrW-1:0]  idx_q;
  logic [tli_pkg::CountW-1:0] count_q;
  logic [tli_pkg::CountW-1:0] limit_q;
  tli_pkg::esc_e              esc_q;
  logic                       out_valid_q;
  tli_pkg::kind_e             kind_q;
  logic [tli_pkg::ByteW-1:0]  value_q;
  logic                       last_q;

  logic [tli_pkg::ByteW-1:0]  line_mem [tli_pkg::LINE_DEPTH];
  logic [tli_pkg::ByteW-1:0]  rdata_q;

  tli_pkg::decode_t           dec;
  logic                       in_xfer;
  logic                       slot_free;
  logic                       out_load;
  logic                       line_end;

  tli_decode u_decode (
    .rx_byte_i     (rx_byte_i),
    .more_waiting_i(more_waiting_i),
    .esc_i         (esc_q),
    .count_i       (count_q),
    .limit_i       (limit_q),
    .dec_o         (dec)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_load    = slot_free && ((state_q == S_EMIT) || (state_q == S_LDATA));
  assign line_end    = (tli_pkg::CountW'(idx_q) == line_len_q - 6'd1);
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer && dec.store) begin
      line_mem[count_q[tli_pkg::AddrW-1:0]] <= rx_byte_i;
    end
    if (state_q == S_LREAD) begin
      rdata_q <= line_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tli_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= tli_pkg::ACT_NONE;
      step_q      <= '0;
      echo_q      <= '0;
      line_len_q  <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      esc_q       <= tli_pkg::ESC_IDLE;
      out_valid_q <= 1'b0;
      kind_q      <= tli_pkg::KIND_ECHO;
      value_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            count_q    <= dec.count_next;
            esc_q      <= dec.esc_next;
            act_q      <= dec.act;
            echo_q     <= dec.echo_byte;
            line_len_q <= count_q;
            step_q     <= '0;
            idx_q      <= '0;
            if (dec.act != tli_pkg::ACT_NONE) begin
              state_q <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            step_q <= step_q + 2'd1;
            unique case (act_q)
              tli_pkg::ACT_ERASE: begin
                kind_q  <= tli_pkg::KIND_ECHO;
                value_q <= (step_q == 2'd1) ? tli_pkg::BYTE_SPACE : tli_pkg::BYTE_BS;
                last_q  <= (step_q == 2'd2);
                if (step_q == 2'd2) begin
                  state_q <= S_IDLE;
                end
              end
              tli_pkg::ACT_ENTER: begin
                if (step_q == 2'd0) begin
                  kind_q  <= tli_pkg::KIND_ECHO;
                  value_q <= tli_pkg::BYTE_CR;
                  last_q  <= 1'b0;
                end else if (step_q == 2'd1) begin
                  kind_q  <= tli_pkg::KIND_ECHO;
                  value_q <= tli_pkg::BYTE_LF;
                  last_q  <= 1'b0;
                  if (line_len_q != '0) begin
                    state_q <= S_LREAD;
                  end
                end else begin
                  kind_q  <= tli_pkg::KIND_EMPTY;
                  value_q <= tli_pkg::BYTE_ZERO;
                  last_q  <= 1'b1;
                  state_q <= S_IDLE;
                end
              end
              default: begin
                kind_q  <= tli_pkg::KIND_ECHO;
                value_q <= echo_q;
                last_q  <= 1'b1;
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_LREAD: begin
          state_q <= S_LDATA;
        end
        S_LDATA: begin
          if (slot_free) begin
            kind_q      <= tli_pkg::KIND_CHAR;
            value_q     <= rdata_q;
            last_q      <= line_end;
            if (line_end) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_LREAD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- dv/tb_terminal_line_input_unit.sv -----
// Self-checking testbench for terminal_line_input_unit: line editing, escapes, line limit.
// Depends on tli_pkg and the RTL of the unit; a line editor model predicts each output transfer.
module tb_terminal_line_input_unit;

  typedef struct {
    tli_pkg::kind_e            kind;
    logic [tli_pkg::ByteW-1:0] value;
    logic                      last;
  } term_out_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall_o;
  logic [tli_pkg::ByteW-1:0]  rx_byte = '0;
  logic                       more_waiting = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall = 1'b0;
  logic [1:0]                 kind_o;
  logic [tli_pkg::ByteW-1:0]  value_o;
  logic                       last_o;
  logic                       cfg_we = 1'b0;
  logic [tli_pkg::CountW-1:0] cfg_wdata = '0;

  term_out_t                  due_output[$];
  int                         mismatches = 0;
  int                         echoing_items = 0;
  int                         snd_idle_pct = 0;
  int                         rcv_idle_pct = 0;
  int                         hold_req = 0;
  int                         hold_left = 0;

  logic [tli_pkg::CountW-1:0] line_limit = tli_pkg::LIMIT_RESET;
  tli_pkg::esc_e              esc_phase = tli_pkg::ESC_IDLE;
  int                         char_count = 0;
  logic [tli_pkg::ByteW-1:0]  line_chars [tli_pkg::LINE_DEPTH];

  terminal_line_input_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte),
    .more_waiting_i (more_waiting),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .kind_o         (kind_o),
    .value_o        (value_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int edit_line(input logic [tli_pkg::ByteW-1:0] b, input logic more);
    term_out_t res[$];
    int        cap;
    cap = (line_limit <= 1) ? 0 : int'(line_limit) - 1;
    if (cap > tli_pkg::LINE_DEPTH - 2) cap = tli_pkg::LINE_DEPTH - 2;
    if (esc_phase == tli_pkg::ESC_AFTER) begin
      if (b == tli_pkg::BYTE_LBRACKET) esc_phase = tli_pkg::ESC_CSI;
      else esc_phase = tli_pkg::ESC_IDLE;
      return 0;
    end
    if (esc_phase == tli_pkg::ESC_CSI) begin
      esc_phase = tli_pkg::ESC_IDLE;
      return 0;
    end
    if (b == tli_pkg::BYTE_CR || b == tli_pkg::BYTE_LF) begin
      res.push_back('{tli_pkg::KIND_ECHO, tli_pkg::BYTE_CR, 1'b0});
      res.push_back('{tli_pkg::KIND_ECHO, tli_pkg::BYTE_LF, 1'b0});
      if (char_count == 0) res.push_back('{tli_pkg::KIND_EMPTY, tli_pkg::BYTE_ZERO, 1'b0});
      for (int i = 0; i < char_count; i++) begin
        res.push_back('{tli_pkg::KIND_CHAR, line_chars[i], 1'b0});
      end
      char_count = 0;
    end else if (b == tli_pkg::BYTE_BS || b == tli_pkg::BYTE_DEL) begin
      if (char_count > 0) begin
        char_count--;
        res.push_back('{tli_pkg::KIND_ECHO, tli_pkg::BYTE_BS, 1'b0});
        res.push_back('{tli_pkg::KIND_ECHO, tli_pkg::BYTE_SPACE, 1'b0});
        res.push_back('{tli_pkg::KIND_ECHO, tli_pkg::BYTE_BS, 1'b0});
      end
    end else if (b == tli_pkg::BYTE_ESC) begin
      if (more) esc_phase = tli_pkg::ESC_AFTER;
    end else if (b >= tli_pkg::BYTE_SPACE && b <= tli_pkg::BYTE_TILDE) begin
      if (char_count >= cap) begin
        res.push_back('{tli_pkg::KIND_ECHO, tli_pkg::BYTE_BELL, 1'b0});
      end else begin
        line_chars[char_count] = b;
        char_count++;
        res.push_back('{tli_pkg::KIND_ECHO, b, 1'b0});
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[k]) due_output.push_back(res[k]);
    return res.size();
  endfunction

  task automatic send_rx_byte(input logic [tli_pkg::ByteW-1:0] b, input logic more);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    rx_byte      <= b;
    more_waiting <= more;
    do @(posedge clk_i); while (in_stall_o);
    if (edit_line(b, more) > 0) echoing_items++;
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (due_output.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_line_limit(input logic [tli_pkg::CountW-1:0] v);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    line_limit = v;
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random_action();
    logic [tli_pkg::ByteW-1:0] b;
    int                        pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_rx_byte(tli_pkg::ByteW'($urandom_range(tli_pkg::BYTE_SPACE, tli_pkg::BYTE_TILDE)),
                   1'($urandom));
    end else if (pick < 65) begin
      send_rx_byte(($urandom_range(1) != 0) ? tli_pkg::BYTE_BS : tli_pkg::BYTE_DEL,
                   1'($urandom));
    end else if (pick < 73) begin
      send_rx_byte(($urandom_range(1) != 0) ? tli_pkg::BYTE_CR : tli_pkg::BYTE_LF,
                   1'($urandom));
    end else if (pick < 83) begin
      send_rx_byte(tli_pkg::BYTE_ESC, 1'b1);
      b = ($urandom_range(99) < 60) ? tli_pkg::BYTE_LBRACKET : tli_pkg::ByteW'($urandom);
      send_rx_byte(b, 1'($urandom));
      if (b == tli_pkg::BYTE_LBRACKET) send_rx_byte(tli_pkg::ByteW'($urandom), 1'($urandom));
    end else begin
      send_rx_byte(tli_pkg::ByteW'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_edit_basics();
    send_rx_byte(tli_pkg::BYTE_SPACE, 1'b0);
    send_rx_byte(tli_pkg::BYTE_TILDE, 1'b1);
    send_rx_byte(8'h1F, 1'b0);
    send_rx_byte(8'hFF, 1'b1);
    send_rx_byte(8'h00, 1'b0);
    send_rx_byte(tli_pkg::BYTE_DEL, 1'b0);
    send_rx_byte(tli_pkg::BYTE_BS, 1'b1);
    send_rx_byte(tli_pkg::BYTE_BS, 1'b0);
    send_rx_byte(tli_pkg::BYTE_CR, 1'b0);
    send_rx_byte(8'h41, 1'b0);
    send_rx_byte(tli_pkg::BYTE_LF, 1'b1);
  endtask

  task automatic test_escape_sequences();
    send_rx_byte(tli_pkg::BYTE_ESC, 1'b0);
    send_rx_byte(8'h41, 1'b0);
    send_rx_byte(tli_pkg::BYTE_ESC, 1'b1);
    send_rx_byte(8'h78, 1'b0);
    send_rx_byte(tli_pkg::BYTE_ESC, 1'b1);
    send_rx_byte(tli_pkg::BYTE_LBRACKET, 1'b1);
    send_rx_byte(tli_pkg::BYTE_ESC, 1'b1);
    send_rx_byte(8'h42, 1'b0);
    send_rx_byte(tli_pkg::BYTE_CR, 1'b0);
  endtask

  task automatic test_line_limits();
    write_line_limit(6'd2);
    send_rx_byte(8'h61, 1'b0);
    send_rx_byte(8'h62, 1'b0);
    send_rx_byte(tli_pkg::BYTE_CR, 1'b0);
    write_line_limit(6'd0);
    send_rx_byte(8'h78, 1'b0);
    write_line_limit(6'd1);
    send_rx_byte(8'h79, 1'b1);
  endtask

  task automatic test_random_editing(input int n, input int snd, input int rcv,
                                     input logic [tli_pkg::CountW-1:0] lim);
    int start;
    write_line_limit(lim);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    start = echoing_items;
    while (echoing_items - start < n) send_random_action();
  endtask

  task automatic test_output_backpressure();
    write_line_limit(6'd63);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 400;
    for (int i = 0; i < 63; i++) begin
      send_rx_byte(tli_pkg::ByteW'($urandom_range(tli_pkg::BYTE_SPACE, tli_pkg::BYTE_TILDE)),
                   1'($urandom));
    end
    send_rx_byte(tli_pkg::BYTE_LF, 1'b0);
    send_rx_byte(8'h7A, 1'b0);
    send_rx_byte(tli_pkg::BYTE_CR, 1'b1);
  endtask

  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    term_out_t head;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (due_output.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer: kind %0d value 0x%02h last %0d",
                 $time, kind_o, value_o, last_o);
      end else begin
        head = due_output.pop_front();
        if (kind_o !== head.kind || value_o !== head.value || last_o !== head.last) begin
          mismatches++;
          $display("%0t: expected kind %0d value 0x%02h last %0d, actual %0d 0x%02h %0d",
                   $time, head.kind, head.value, head.last, kind_o, value_o, last_o);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    snd_idle_pct = 31;
    rcv_idle_pct = 85;
    test_edit_basics();
    test_escape_sequences();
    test_line_limits();
    test_random_editing(55, 31, 85, 6'd63);
    test_random_editing(55, 85, 31, 6'($urandom_range(2, 20)));
    test_random_editing(45, 0, 0, 6'd7);
    test_output_backpressure();
    settle_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
